/* rtl/core/tlseq_pkg.sv */
// Package for the two-way traffic light sequencer.
// Holds phase codes, lamp decoding, register indexes and shared structs.
// No dependencies.
package tlseq_pkg;

    localparam int CounterWidthDefault = 16;
    localparam int CfgWidth            = 16;
    localparam int CfgIndexWidth       = 2;
    localparam int DigitWidth          = 4;

    localparam logic [CfgWidth-1:0]   PhaseTicksReset   = 16'd50;
    localparam logic [CfgWidth-1:0]   AllRedTicksReset  = 16'd20;
    localparam logic [CfgWidth-1:0]   DigitTicksReset   = 16'd10;
    localparam logic [CfgWidth-1:0]   PedTailTicksReset = 16'd3;
    localparam logic [DigitWidth-1:0] CountdownStart    = 4'd9;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_PHASE_TICKS    = 2'd0,
        CFG_ALL_RED_TICKS  = 2'd1,
        CFG_DIGIT_TICKS    = 2'd2,
        CFG_PED_TAIL_TICKS = 2'd3
    } cfg_index_t;

    typedef enum logic [14:0] {
        PH_U0      = 15'h0001,
        PH_U1      = 15'h0002,
        PH_U2      = 15'h0004,
        PH_U3      = 15'h0008,
        PH_ALLRED  = 15'h0010,
        PH_B_GREEN = 15'h0020,
        PH_B_AMBER = 15'h0040,
        PH_B_RED   = 15'h0080,
        PH_PED_1   = 15'h0100,
        PH_TAIL_1  = 15'h0200,
        PH_A_GREEN = 15'h0400,
        PH_A_AMBER = 15'h0800,
        PH_A_RED   = 15'h1000,
        PH_PED_2   = 15'h2000,
        PH_TAIL_2  = 15'h4000
    } phase_t;

    typedef struct packed {
        logic [CfgWidth-1:0] phase_ticks;
        logic [CfgWidth-1:0] all_red_ticks;
        logic [CfgWidth-1:0] digit_ticks;
        logic [CfgWidth-1:0] ped_tail_ticks;
    } cfg_t;

    typedef struct packed {
        logic red_a;
        logic amber_a;
        logic green_a;
        logic red_b;
        logic amber_b;
        logic green_b;
    } lamps_t;

    typedef struct packed {
        lamps_t                lamps;
        logic [DigitWidth-1:0] digit;
        logic                  digit_on;
    } result_t;

    localparam lamps_t LampsAllRed = '{red_a: 1'b1, red_b: 1'b1, default: 1'b0};

    function automatic lamps_t phase_lamps(input phase_t ph);
        lamps_t l;
        l = LampsAllRed;
        case (ph)
            PH_U0, PH_B_GREEN: begin
                l = '{red_a: 1'b1, green_b: 1'b1, default: 1'b0};
            end
            PH_U1, PH_B_AMBER: begin
                l = '{red_a: 1'b1, amber_b: 1'b1, default: 1'b0};
            end
            PH_U2, PH_A_GREEN: begin
                l = '{green_a: 1'b1, red_b: 1'b1, default: 1'b0};
            end
            PH_U3, PH_A_AMBER: begin
                l = '{amber_a: 1'b1, red_b: 1'b1, default: 1'b0};
            end
            default: begin
                l = LampsAllRed;
            end
        endcase
        return l;
    endfunction

endpackage

/* rtl/core/tlseq_cfg.sv */
// Configuration registers of the traffic light sequencer.
// Written through a plain write port; depends on tlseq_pkg.
module tlseq_cfg (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [tlseq_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [tlseq_pkg::CfgWidth-1:0]         cfg_wdata,
    output tlseq_pkg::cfg_t                        cfg
);

    tlseq_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_ticks    <= tlseq_pkg::PhaseTicksReset;
            cfg_reg.all_red_ticks  <= tlseq_pkg::AllRedTicksReset;
            cfg_reg.digit_ticks    <= tlseq_pkg::DigitTicksReset;
            cfg_reg.ped_tail_ticks <= tlseq_pkg::PedTailTicksReset;
        end else if (cfg_wr_en) begin
            case (tlseq_pkg::cfg_index_t'(cfg_index))
                tlseq_pkg::CFG_PHASE_TICKS:    cfg_reg.phase_ticks    <= cfg_wdata;
                tlseq_pkg::CFG_ALL_RED_TICKS:  cfg_reg.all_red_ticks  <= cfg_wdata;
                tlseq_pkg::CFG_DIGIT_TICKS:    cfg_reg.digit_ticks    <= cfg_wdata;
                tlseq_pkg::CFG_PED_TAIL_TICKS: cfg_reg.ped_tail_ticks <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/tlseq_core.sv */
// Phase sequencer of the traffic light block: mode, request latch, phase,
// tick counter and countdown, plus the decoded lamps. Depends on tlseq_pkg.
module tlseq_core #(
    parameter int COUNTER_WIDTH = tlseq_pkg::CounterWidthDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_valid,
    input  logic                 tick,
    input  logic                 mode_press,
    input  logic                 ped_press,
    input  tlseq_pkg::cfg_t      cfg,
    output tlseq_pkg::result_t   result
);

    localparam int LimWidth = (COUNTER_WIDTH > tlseq_pkg::CfgWidth) ?
                              COUNTER_WIDTH : tlseq_pkg::CfgWidth;
    localparam logic [LimWidth-1:0] CountMax = LimWidth'({COUNTER_WIDTH{1'b1}});

    logic                                safe_mode_reg, safe_mode_next;
    logic                                safe_run_reg, safe_run_next;
    logic                                ped_latched_reg, ped_latched_next;
    tlseq_pkg::phase_t                   phase_reg, phase_next;
    logic [COUNTER_WIDTH-1:0]            tick_count_reg, tick_count_next;
    logic [tlseq_pkg::DigitWidth-1:0]    countdown_reg, countdown_next;

    logic [tlseq_pkg::CfgWidth-1:0]      phase_len;
    logic [tlseq_pkg::CfgWidth-1:0]      lim_raw;
    logic [LimWidth-1:0]                 lim;
    logic                                in_count;
    logic                                is_ped;

    // Length of the running phase and the last count value in it.
    always_comb begin
        case (phase_reg)
            tlseq_pkg::PH_ALLRED:                        phase_len = cfg.all_red_ticks;
            tlseq_pkg::PH_PED_1, tlseq_pkg::PH_PED_2:   phase_len = cfg.digit_ticks;
            tlseq_pkg::PH_TAIL_1, tlseq_pkg::PH_TAIL_2: phase_len = cfg.ped_tail_ticks;
            default:                                     phase_len = cfg.phase_ticks;
        endcase
        lim_raw = (phase_len == '0) ? '0 : phase_len - 1'b1;
        lim     = (LimWidth'(lim_raw) > CountMax) ? CountMax : LimWidth'(lim_raw);
    end

    assign in_count = LimWidth'(tick_count_reg) < lim;
    assign is_ped   = (phase_reg == tlseq_pkg::PH_PED_1) ||
                      (phase_reg == tlseq_pkg::PH_PED_2);

    always_comb begin
        logic safe_t;
        logic ped_t;
        logic after_b;
        logic check_ped;
        logic finish_ped;

        safe_mode_next   = safe_mode_reg;
        safe_run_next    = safe_run_reg;
        ped_latched_next = ped_latched_reg;
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        countdown_next   = countdown_reg;

        // Presses of an item take effect before its tick.
        safe_t     = safe_mode_reg ^ mode_press;
        ped_t      = ped_latched_reg | ped_press;
        after_b    = 1'b0;
        check_ped  = 1'b0;
        finish_ped = 1'b0;

        if (step_valid) begin
            safe_mode_next   = safe_t;
            ped_latched_next = ped_t;
            if (tick) begin
                if (in_count) begin
                    tick_count_next = tick_count_reg + 1'b1;
                end else begin
                    tick_count_next = '0;
                    case (phase_reg)
                        tlseq_pkg::PH_U0:      phase_next = tlseq_pkg::PH_U1;
                        tlseq_pkg::PH_U1:      phase_next = tlseq_pkg::PH_U2;
                        tlseq_pkg::PH_U2:      phase_next = tlseq_pkg::PH_U3;
                        tlseq_pkg::PH_ALLRED:  phase_next = tlseq_pkg::PH_B_GREEN;
                        tlseq_pkg::PH_B_GREEN: phase_next = tlseq_pkg::PH_B_AMBER;
                        tlseq_pkg::PH_B_AMBER: phase_next = tlseq_pkg::PH_B_RED;
                        tlseq_pkg::PH_A_GREEN: phase_next = tlseq_pkg::PH_A_AMBER;
                        tlseq_pkg::PH_A_AMBER: phase_next = tlseq_pkg::PH_A_RED;
                        tlseq_pkg::PH_B_RED: begin
                            check_ped = 1'b1;
                            after_b   = 1'b1;
                        end
                        tlseq_pkg::PH_A_RED: begin
                            check_ped = 1'b1;
                        end
                        tlseq_pkg::PH_PED_1, tlseq_pkg::PH_PED_2: begin
                            after_b = (phase_reg == tlseq_pkg::PH_PED_1);
                            if (countdown_reg != '0 &&
                                countdown_reg <= tlseq_pkg::CountdownStart) begin
                                countdown_next = countdown_reg - 1'b1;
                            end else if (cfg.ped_tail_ticks != '0) begin
                                phase_next = after_b ? tlseq_pkg::PH_TAIL_1 :
                                                       tlseq_pkg::PH_TAIL_2;
                            end else begin
                                finish_ped = 1'b1;
                            end
                        end
                        tlseq_pkg::PH_TAIL_1: begin
                            finish_ped = 1'b1;
                            after_b    = 1'b1;
                        end
                        default: begin
                            // End of an unsafe cycle or of the second tail.
                            finish_ped = 1'b1;
                        end
                    endcase

                    if (check_ped && ped_t) begin
                        ped_latched_next = 1'b0;
                        countdown_next   = tlseq_pkg::CountdownStart;
                        phase_next       = after_b ? tlseq_pkg::PH_PED_1 :
                                                     tlseq_pkg::PH_PED_2;
                    end else if (check_ped || finish_ped) begin
                        if (after_b) begin
                            phase_next = tlseq_pkg::PH_A_GREEN;
                        end else begin
                            // A new cycle samples the mode.
                            safe_run_next = safe_t;
                            phase_next    = safe_t ? tlseq_pkg::PH_ALLRED :
                                                     tlseq_pkg::PH_U0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            safe_mode_reg   <= 1'b0;
            safe_run_reg    <= 1'b0;
            ped_latched_reg <= 1'b0;
            phase_reg       <= tlseq_pkg::PH_U0;
            tick_count_reg  <= '0;
            countdown_reg   <= tlseq_pkg::CountdownStart;
        end else begin
            safe_mode_reg   <= safe_mode_next;
            safe_run_reg    <= safe_run_next;
            ped_latched_reg <= ped_latched_next;
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            countdown_reg   <= countdown_next;
        end
    end

    // The result shows the state after the item.
    always_comb begin
        result.lamps    = tlseq_pkg::phase_lamps(phase_next);
        result.digit_on = (phase_next == tlseq_pkg::PH_PED_1) ||
                          (phase_next == tlseq_pkg::PH_PED_2);
        result.digit    = result.digit_on ? countdown_next : '0;
    end

    a_countdown_range: assert property (@(posedge aclk) disable iff (!aresetn)
        countdown_reg <= tlseq_pkg::CountdownStart)
        else $error("countdown left its range");

    a_unsafe_phases: assert property (@(posedge aclk) disable iff (!aresetn)
        !safe_run_reg |-> (phase_reg == tlseq_pkg::PH_U0 || phase_reg == tlseq_pkg::PH_U1 ||
                           phase_reg == tlseq_pkg::PH_U2 || phase_reg == tlseq_pkg::PH_U3))
        else $error("safe phase reached in an unsafe cycle");

    a_request_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_valid && !is_ped && (phase_next == tlseq_pkg::PH_PED_1 ||
                                   phase_next == tlseq_pkg::PH_PED_2))
        |=> (!ped_latched_reg && countdown_reg == tlseq_pkg::CountdownStart))
        else $error("pedestrian phase entered without clearing the request");

endmodule

/* rtl/core/two_way_traffic_light_sequencer.sv */
// Two-way traffic light sequencer, top level.
// An item passes through the input register and then the result register to m_tvalid; it can wait between them.
// Throughput: one item per cycle while m_tready stays high; the phase next-state logic is combinational.
// Input register and result register decouple the two sides, so s_tready stays high
// while a result waits, unless both stages hold items.
// Reset (synchronous, active low): unsafe mode, first phase, no request, stages empty.
module two_way_traffic_light_sequencer #(
    parameter int COUNTER_WIDTH = tlseq_pkg::CounterWidthDefault
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // tick, mode_press, ped_press
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // red_a, amber_a, green_a, red_b,
                                                           // amber_b, green_b, digit[3:0], digit_on
    input  logic                                cfg_wr_en,
    input  logic [tlseq_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [tlseq_pkg::CfgWidth-1:0]      cfg_wdata
);

    logic               in_valid_reg;
    logic [2:0]         in_data_reg;
    logic               step;
    logic               out_valid_reg;
    tlseq_pkg::result_t out_reg;
    tlseq_pkg::result_t result;
    tlseq_pkg::cfg_t    cfg;

    // The input item moves on when the result register is free or draining.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[2:0];
        end
        if (step) begin
            out_reg <= result;
        end
    end

    tlseq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tlseq_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (step),
        .tick       (in_data_reg[0]),
        .mode_press (in_data_reg[1]),
        .ped_press  (in_data_reg[2]),
        .cfg        (cfg),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.digit_on, out_reg.digit,
                       out_reg.lamps.green_b, out_reg.lamps.amber_b, out_reg.lamps.red_b,
                       out_reg.lamps.green_a, out_reg.lamps.amber_a, out_reg.lamps.red_a};

    a_item_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("buffered item did not reach the result register");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result changed or vanished");

endmodule
